@@ rtl/sld_pkg.sv @@
// Package for the sync / length / checksum deframer.
// Holds the parse state type, result record, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package sld_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = CFG_IDX_W'(1);

    localparam logic [7:0] SYNC_RESET = 8'hFF;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef enum logic [7:0] {
        ST_HUNT   = 8'b0000_0001,
        ST_SECOND = 8'b0000_0010,
        ST_DEV    = 8'b0000_0100,
        ST_INSTR  = 8'b0000_1000,
        ST_LEN    = 8'b0001_0000,
        ST_DATA   = 8'b0010_0000,
        ST_SUMLO  = 8'b0100_0000,
        ST_SUMHI  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] unit_id;
        logic [7:0] instruction_code;
        logic [7:0] payload_length;
        logic       frame_status;
        logic       last_of_packet;
    } t_result;

endpackage

@@ rtl/sync_length_checksum_deframer_top.sv @@
// A result is registered in the output buffer when its byte is accepted and is offered from there.
// The input takes one byte per cycle; a two-entry output buffer absorbs stalls, and
// the input stalls only while both entries hold untaken results.
// Reset (synchronous, active low): parser back to header hunt, sync bytes to 0xFF,
// held fields and sum cleared, output buffer emptied. Config writes always accepted.
`timescale 1ns / 1ps

module sync_length_checksum_deframer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_result_kind,
    output logic [7:0]                    o_payload_byte,
    output logic [7:0]                    o_payload_index,
    output logic [7:0]                    o_unit_id,
    output logic [7:0]                    o_instruction_code,
    output logic [7:0]                    o_payload_length,
    output logic                          o_frame_status,
    output logic                          o_last_of_packet,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sld_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    logic             accept;
    logic             full;
    logic             res_valid;
    sld_pkg::t_result res;
    sld_pkg::t_result out_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    sld_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sld_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_result_kind      = out_res.result_kind;
    assign o_payload_byte     = out_res.payload_byte;
    assign o_payload_index    = out_res.payload_index;
    assign o_unit_id          = out_res.unit_id;
    assign o_instruction_code = out_res.instruction_code;
    assign o_payload_length   = out_res.payload_length;
    assign o_frame_status     = out_res.frame_status;
    assign o_last_of_packet   = out_res.last_of_packet;

endmodule

@@ rtl/sld_parser.sv @@
// Byte parser: header hunt, field capture, running 16-bit sum, result build.
// Also holds the two sync byte registers. Depends on sld_pkg.
`timescale 1ns / 1ps

module sld_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [7:0]                   i_rx_byte,
    input  logic                         i_cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                   i_cfg_data,
    output logic                         o_res_valid,
    output sld_pkg::t_result             o_res
);

    sld_pkg::t_state r_state, n_state;
    logic [7:0]  r_sync_first, n_sync_first;
    logic [7:0]  r_sync_second, n_sync_second;
    logic [7:0]  r_dev, n_dev;
    logic [7:0]  r_instr, n_instr;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_seen, n_seen;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_rxlo, n_rxlo;
    logic [7:0]  seen_inc;
    logic [15:0] sum_add;

    assign seen_inc = r_seen + 8'd1;
    assign sum_add  = r_sum + {8'h00, i_rx_byte};

    always_comb begin
        n_sync_first  = r_sync_first;
        n_sync_second = r_sync_second;
        if (i_cfg_we) begin
            case (i_cfg_index)
                sld_pkg::CFG_SYNC_FIRST:  n_sync_first  = i_cfg_data;
                sld_pkg::CFG_SYNC_SECOND: n_sync_second = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_dev       = r_dev;
        n_instr     = r_instr;
        n_len       = r_len;
        n_seen      = r_seen;
        n_sum       = r_sum;
        n_rxlo      = r_rxlo;
        o_res_valid = 1'b0;
        o_res                  = '0;
        o_res.unit_id          = r_dev;
        o_res.instruction_code = r_instr;
        o_res.payload_length   = r_len;
        case (r_state)
            sld_pkg::ST_HUNT: begin
                if (i_rx_byte == r_sync_first) begin
                    n_sum   = {8'h00, i_rx_byte};
                    n_state = sld_pkg::ST_SECOND;
                end
            end
            sld_pkg::ST_SECOND: begin
                if (i_rx_byte == r_sync_second) begin
                    n_sum   = sum_add;
                    n_state = sld_pkg::ST_DEV;
                end else if (i_rx_byte == r_sync_first) begin
                    n_sum   = {8'h00, i_rx_byte};
                end else begin
                    n_state = sld_pkg::ST_HUNT;
                end
            end
            sld_pkg::ST_DEV: begin
                n_dev   = i_rx_byte;
                n_sum   = sum_add;
                n_state = sld_pkg::ST_INSTR;
            end
            sld_pkg::ST_INSTR: begin
                n_instr = i_rx_byte;
                n_sum   = sum_add;
                n_state = sld_pkg::ST_LEN;
            end
            sld_pkg::ST_LEN: begin
                n_len   = i_rx_byte;
                n_sum   = sum_add;
                n_seen  = 8'd0;
                n_state = (i_rx_byte == 8'd0) ? sld_pkg::ST_SUMLO : sld_pkg::ST_DATA;
            end
            sld_pkg::ST_DATA: begin
                n_sum               = sum_add;
                o_res_valid         = 1'b1;
                o_res.result_kind   = sld_pkg::KIND_PAYLOAD;
                o_res.payload_byte  = i_rx_byte;
                o_res.payload_index = r_seen;
                n_seen              = seen_inc;
                if (seen_inc == r_len) begin
                    n_state = sld_pkg::ST_SUMLO;
                end
            end
            sld_pkg::ST_SUMLO: begin
                n_rxlo  = i_rx_byte;
                n_state = sld_pkg::ST_SUMHI;
            end
            sld_pkg::ST_SUMHI: begin
                o_res_valid          = 1'b1;
                o_res.result_kind    = sld_pkg::KIND_END;
                o_res.frame_status   = ({i_rx_byte, r_rxlo} != r_sum);
                o_res.last_of_packet = 1'b1;
                n_state              = sld_pkg::ST_HUNT;
            end
            default: begin
                n_state = sld_pkg::ST_HUNT;
            end
        endcase
        if (!i_accept) begin
            n_state     = r_state;
            n_dev       = r_dev;
            n_instr     = r_instr;
            n_len       = r_len;
            n_seen      = r_seen;
            n_sum       = r_sum;
            n_rxlo      = r_rxlo;
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sld_pkg::ST_HUNT;
            r_sync_first  <= sld_pkg::SYNC_RESET;
            r_sync_second <= sld_pkg::SYNC_RESET;
            r_dev         <= 8'd0;
            r_instr       <= 8'd0;
            r_len         <= 8'd0;
            r_seen        <= 8'd0;
            r_sum         <= 16'd0;
            r_rxlo        <= 8'd0;
        end else begin
            r_state       <= n_state;
            r_sync_first  <= n_sync_first;
            r_sync_second <= n_sync_second;
            r_dev         <= n_dev;
            r_instr       <= n_instr;
            r_len         <= n_len;
            r_seen        <= n_seen;
            r_sum         <= n_sum;
            r_rxlo        <= n_rxlo;
        end
    end

    // payload index never reaches the declared length
    a_seen_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sld_pkg::ST_DATA) |-> (r_seen < r_len))
        else $error("payload count reached length while in data phase");

    // results come only from data or checksum-high phase
    a_res_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (i_accept && (r_state == sld_pkg::ST_DATA ||
                                      r_state == sld_pkg::ST_SUMHI)))
        else $error("result outside data or checksum phase");

    // zero length skips the payload phase
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_state == sld_pkg::ST_LEN && i_rx_byte == 8'd0)
        |=> (r_state == sld_pkg::ST_SUMLO))
        else $error("zero length did not go to checksum");

endmodule

@@ rtl/sld_outbuf.sv @@
// Two-entry output buffer between the parser and the result channel.
// Lets the parser take a byte while a result waits. Depends on sld_pkg.
`timescale 1ns / 1ps

module sld_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sld_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output sld_pkg::t_result o_data
);

    sld_pkg::t_result r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full output buffer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("output buffer count out of range");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_wr_ptr ^ r_rd_ptr) == r_count[0]))
        else $error("buffer pointers disagree with count");

endmodule
